[hw/rtl/asp_pkg.sv]
// Shared types, constants and step functions for the turret aim solver.
// Used by the channel interfaces, the cell modules and the top level.
package asp_pkg;

   localparam int MIN_DIST_MM_DEF = 100;
   localparam int ANGLE_ITER_DEF  = 16;
   localparam int TAB_LEN         = 24;
   localparam int FRAC_SHIFT      = 12;

   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam logic [13:0] GRAVITY_RST = 14'd9800;

   localparam int ANG_W = 28;   // angle accumulator, 1/4096 centidegree
   localparam int CX_W  = 34;   // CORDIC x/y
   localparam int NUM_W = 56;   // pitch numerator / denominator
   localparam int N_W   = 42;   // sqrt radicand, h2 in Q8
   localparam int HQ_W  = 21;   // sqrt result
   localparam int MAG_W = 17;   // |rx|, |ry|

   localparam int QUARTER = 9000;
   localparam int HALF    = 18000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OFFSET_X = 8'd0,
      REG_OFFSET_Y = 8'd1,
      REG_OFFSET_Z = 8'd2,
      REG_GRAVITY  = 8'd3
   } csr_idx_type;

   typedef struct packed {
      logic too_close;
      logic no_sol;
      logic h2_zero;
      logic rz_pos;
      logic rz_neg;
      logic yaw_xneg;
      logic yaw_yneg;
      logic pit_yneg;
   } flag_type;

   typedef struct packed {
      logic [N_W-1:0] n;
      logic [N_W-1:0] res;
   } sq_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic [31:0]             v2;
      logic [MAG_W-1:0]        yax;
      logic [MAG_W-1:0]        yay;
      flag_type                flags;
   } sq_side_type;

   typedef struct packed {
      logic [NUM_W-1:0] ax;
      logic [NUM_W-1:0] ay;
   } pair_type;

   typedef struct packed {
      logic [MAG_W-1:0] yax;
      logic [MAG_W-1:0] yay;
      flag_type         flags;
   } norm_side_type;

   typedef struct packed {
      logic signed [CX_W-1:0]  x;
      logic signed [CX_W-1:0]  y;
      logic signed [ANG_W-1:0] ang;
   } cordic_type;

   function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
      logic signed [ANG_W-1:0] r;
      unique case (idx)
         0:  r = 28'sd18432000;
         1:  r = 28'sd10881045;
         2:  r = 28'sd5749245;
         3:  r = 28'sd2918407;
         4:  r = 28'sd1464867;
         5:  r = 28'sd733147;
         6:  r = 28'sd366663;
         7:  r = 28'sd183343;
         8:  r = 28'sd91673;
         9:  r = 28'sd45837;
         10: r = 28'sd22918;
         11: r = 28'sd11459;
         12: r = 28'sd5730;
         13: r = 28'sd2865;
         14: r = 28'sd1432;
         15: r = 28'sd716;
         16: r = 28'sd358;
         17: r = 28'sd179;
         18: r = 28'sd90;
         19: r = 28'sd45;
         20: r = 28'sd22;
         21: r = 28'sd11;
         22: r = 28'sd6;
         23: r = 28'sd3;
         default: r = '0;
      endcase
      return r;
   endfunction

   // shift toward zero
   function automatic logic signed [CX_W-1:0] shr_tz(input logic signed [CX_W-1:0] v,
                                                     input int s);
      logic signed [CX_W-1:0] r;
      if (v[CX_W-1]) r = -((-v) >>> s);
      else r = v >>> s;
      return r;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type c, input int i);
      cordic_type r;
      logic signed [CX_W-1:0] ty;
      logic signed [CX_W-1:0] tx;
      ty = shr_tz(c.y, i);
      tx = shr_tz(c.x, i);
      if (!c.y[CX_W-1]) begin
         r.x   = c.x + ty;
         r.y   = c.y - tx;
         r.ang = c.ang + atan_tab(i);
      end else begin
         r.x   = c.x - ty;
         r.y   = c.y + tx;
         r.ang = c.ang - atan_tab(i);
      end
      return r;
   endfunction

   // round, clamp and mirror into the quadrant
   function automatic logic signed [15:0] angle_out(input logic signed [ANG_W-1:0] ang,
                                                    input logic xneg, input logic yneg);
      logic [ANG_W-1:0]   a0;
      logic [ANG_W-1:0]   r;
      logic [15:0]        a;
      logic signed [15:0] s;
      a0 = ang[ANG_W-1] ? '0 : ang;
      r  = (a0 + ANG_W'(1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
      a  = (r > ANG_W'(QUARTER)) ? 16'(QUARTER) : r[15:0];
      s  = xneg ? 16'(HALF) - a : a;
      if (yneg) s = -s;
      return s;
   endfunction

endpackage

[hw/rtl/asp_if.sv]
// Request, response and register-write channel interfaces of the aim solver.
// Depends on asp_pkg.
interface asp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] target_x;
   logic signed [15:0] target_y;
   logic signed [15:0] target_z;
   logic [15:0]        muzzle_speed;
   modport source (output valid, target_x, target_y, target_z, muzzle_speed, input ready);
   modport sink   (input valid, target_x, target_y, target_z, muzzle_speed, output ready);
endinterface

interface asp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw;
   logic signed [14:0] pitch;
   logic               too_close;
   logic               no_solution;
   modport source (output valid, yaw, pitch, too_close, no_solution, input ready);
   modport sink   (input valid, yaw, pitch, too_close, no_solution, output ready);
endinterface

interface asp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [asp_pkg::CSR_IDX_W-1:0]  index;
   logic [asp_pkg::CSR_DAT_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/asp_sqrt_cell.sv]
// One restoring square-root cell: settles one result bit per stage.
// Depends on asp_pkg.
module asp_sqrt_cell #(
   parameter int K = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  asp_pkg::sq_type      in_sq,
   input  asp_pkg::sq_side_type in_side,
   output logic                 out_valid,
   output asp_pkg::sq_type      out_sq,
   output asp_pkg::sq_side_type out_side
);
   localparam logic [asp_pkg::N_W-1:0] BIT = asp_pkg::N_W'(1) << (asp_pkg::N_W - 2 - 2 * K);

   logic                 valid_ff;
   asp_pkg::sq_type      sq_ff, sq_in;
   asp_pkg::sq_side_type side_ff;
   logic [asp_pkg::N_W-1:0] trial;

   always_comb begin
      trial = in_sq.res + BIT;
      if (in_sq.n >= trial) begin
         sq_in.n   = in_sq.n - trial;
         sq_in.res = (in_sq.res >> 1) + BIT;
      end else begin
         sq_in.n   = in_sq.n;
         sq_in.res = in_sq.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_sq    = sq_ff;
   assign out_side  = side_ff;
endmodule

[hw/rtl/asp_norm_cell.sv]
// One normalizing cell: shifts both magnitudes right by SH when still too wide.
// Depends on asp_pkg.
module asp_norm_cell #(
   parameter int SH = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  asp_pkg::pair_type      in_pair,
   input  asp_pkg::norm_side_type in_side,
   output logic                   out_valid,
   output asp_pkg::pair_type      out_pair,
   output asp_pkg::norm_side_type out_side
);
   logic                   valid_ff;
   asp_pkg::pair_type      pair_ff, pair_in;
   asp_pkg::norm_side_type side_ff;
   logic [asp_pkg::NUM_W-1:0] m;

   always_comb begin
      m = in_pair.ax | in_pair.ay;
      if (|m[asp_pkg::NUM_W-1:29+SH]) begin
         pair_in.ax = in_pair.ax >> SH;
         pair_in.ay = in_pair.ay >> SH;
      end else begin
         pair_in = in_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pair_ff <= pair_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_pair  = pair_ff;
   assign out_side  = side_ff;
endmodule

[hw/rtl/asp_cordic_cell.sv]
// One CORDIC vectoring cell, yaw and pitch lanes side by side.
// Depends on asp_pkg.
module asp_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  asp_pkg::cordic_type  in_yaw,
   input  asp_pkg::cordic_type  in_pit,
   input  asp_pkg::flag_type    in_flags,
   output logic                 out_valid,
   output asp_pkg::cordic_type  out_yaw,
   output asp_pkg::cordic_type  out_pit,
   output asp_pkg::flag_type    out_flags
);
   logic                valid_ff;
   asp_pkg::cordic_type yaw_ff, pit_ff;
   asp_pkg::flag_type   flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_ff   <= asp_pkg::cordic_step(in_yaw, IDX);
         pit_ff   <= asp_pkg::cordic_step(in_pit, IDX);
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_yaw   = yaw_ff;
   assign out_pit   = pit_ff;
   assign out_flags = flags_ff;
endmodule

[hw/rtl/turret_yaw_pitch_aim_solver.sv]
// Turret aim solver top level: offsets, squares, sqrt, normalize and CORDIC chains.
// Depends on asp_pkg, asp_if, asp_sqrt_cell, asp_norm_cell, asp_cordic_cell.
//
// Takes one aiming request per clock unless the output stalls, and returns one
// response per request, in order. The pipeline holds the offset, squaring and
// numerator stages s1 to s5, 21 square-root cells, the denominator multiply
// register, five normalizing cells, ANGLE_ITER CORDIC cells and the output
// register. The whole pipeline holds while a response waits with rsp_ch.ready
// low. Offsets are applied as a request is accepted, but gravity is read later, by
// the s4 numerator multiply, so write registers only while no request is in flight.
module turret_yaw_pitch_aim_solver #(
   parameter int MIN_DIST_MM = asp_pkg::MIN_DIST_MM_DEF,
   parameter int ANGLE_ITER  = asp_pkg::ANGLE_ITER_DEF
) (
   input logic          clock,
   input logic          reset,
   asp_req_if.sink      req_ch,
   asp_rsp_if.source    rsp_ch,
   asp_csr_if.sink      csr_ch
);
   localparam logic [34:0] MIN_D2 = 35'(MIN_DIST_MM * MIN_DIST_MM);
   localparam int NSQ   = asp_pkg::HQ_W;
   localparam int NNORM = 5;

   logic signed [15:0] off_x_ff, off_y_ff, off_z_ff;
   logic [13:0]        grav_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
         grav_ff  <= asp_pkg::GRAVITY_RST;
      end else if (csr_ch.valid) begin
         unique case (asp_pkg::csr_idx_type'(csr_ch.index))
            asp_pkg::REG_OFFSET_X: off_x_ff <= csr_ch.data;
            asp_pkg::REG_OFFSET_Y: off_y_ff <= csr_ch.data;
            asp_pkg::REG_OFFSET_Z: off_z_ff <= csr_ch.data;
            asp_pkg::REG_GRAVITY:  grav_ff  <= csr_ch.data[13:0];
            default: ;
         endcase
      end
   end

   logic out_valid_ff;
   logic adv;
   assign adv = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // s1: relative vector
   logic               s1_v_ff;
   logic signed [16:0] s1_rx_ff, s1_ry_ff, s1_rz_ff;
   logic [15:0]        s1_spd_ff;
   // s2: squares
   logic               s2_v_ff;
   logic signed [16:0] s2_rx_ff, s2_ry_ff, s2_rz_ff;
   logic [32:0]        s2_rx2_ff, s2_ry2_ff, s2_rz2_ff;
   logic [31:0]        s2_v2_ff;
   logic               s2_nos_ff;
   logic signed [33:0] rx_sq, ry_sq, rz_sq;
   // s3: sums
   logic               s3_v_ff;
   logic signed [16:0] s3_rx_ff, s3_ry_ff, s3_rz_ff;
   logic [33:0]        s3_h2_ff;
   logic [31:0]        s3_v2_ff;
   logic               s3_nos_ff, s3_close_ff;
   logic [33:0]        h2_sum;
   logic [34:0]        d2_sum;
   // s4: numerator products
   logic               s4_v_ff;
   logic signed [49:0] s4_p1_ff;
   logic [47:0]        s4_p2_ff;
   logic [33:0]        s4_h2_ff;
   logic [31:0]        s4_v2_ff;
   logic [asp_pkg::MAG_W-1:0] s4_yax_ff, s4_yay_ff;
   asp_pkg::flag_type  s4_flags_ff;
   logic signed [49:0] p1;
   logic [47:0]        p2;
   asp_pkg::flag_type  s4_flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_ch.valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_comb begin
      rx_sq  = s1_rx_ff * s1_rx_ff;
      ry_sq  = s1_ry_ff * s1_ry_ff;
      rz_sq  = s1_rz_ff * s1_rz_ff;
      h2_sum = {1'b0, s2_rx2_ff} + {1'b0, s2_ry2_ff};
      d2_sum = {1'b0, h2_sum} + {2'b0, s2_rz2_ff};
      p1     = s3_rz_ff * $signed({1'b0, s3_v2_ff});
      p2     = grav_ff * s3_h2_ff;
      s4_flags_in.too_close = s3_close_ff;
      s4_flags_in.no_sol    = s3_nos_ff;
      s4_flags_in.h2_zero   = (s3_h2_ff == '0);
      s4_flags_in.rz_pos    = !s3_rz_ff[16] && (s3_rz_ff != '0);
      s4_flags_in.rz_neg    = s3_rz_ff[16];
      s4_flags_in.yaw_xneg  = s3_rx_ff[16];
      s4_flags_in.yaw_yneg  = s3_ry_ff[16];
      s4_flags_in.pit_yneg  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_rx_ff  <= {req_ch.target_x[15], req_ch.target_x} - {off_x_ff[15], off_x_ff};
         s1_ry_ff  <= {req_ch.target_y[15], req_ch.target_y} - {off_y_ff[15], off_y_ff};
         s1_rz_ff  <= {req_ch.target_z[15], req_ch.target_z} - {off_z_ff[15], off_z_ff};
         s1_spd_ff <= req_ch.muzzle_speed;

         s2_rx_ff  <= s1_rx_ff;
         s2_ry_ff  <= s1_ry_ff;
         s2_rz_ff  <= s1_rz_ff;
         s2_rx2_ff <= rx_sq[32:0];
         s2_ry2_ff <= ry_sq[32:0];
         s2_rz2_ff <= rz_sq[32:0];
         s2_v2_ff  <= s1_spd_ff * s1_spd_ff;
         s2_nos_ff <= (s1_spd_ff == '0);

         s3_rx_ff    <= s2_rx_ff;
         s3_ry_ff    <= s2_ry_ff;
         s3_rz_ff    <= s2_rz_ff;
         s3_h2_ff    <= h2_sum;
         s3_v2_ff    <= s2_v2_ff;
         s3_nos_ff   <= s2_nos_ff;
         s3_close_ff <= (d2_sum < MIN_D2);

         s4_p1_ff    <= p1;
         s4_p2_ff    <= p2;
         s4_h2_ff    <= s3_h2_ff;
         s4_v2_ff    <= s3_v2_ff;
         s4_yax_ff   <= s3_rx_ff[16] ? 17'(-s3_rx_ff) : s3_rx_ff[16:0];
         s4_yay_ff   <= s3_ry_ff[16] ? 17'(-s3_ry_ff) : s3_ry_ff[16:0];
         s4_flags_ff <= s4_flags_in;
      end
   end

   // s5: numerator sum, feeds the sqrt chain
   logic                 sq_v [0:NSQ];
   asp_pkg::sq_type      sq_s [0:NSQ];
   asp_pkg::sq_side_type sq_d [0:NSQ];
   logic signed [asp_pkg::NUM_W-1:0] num_sum;
   asp_pkg::sq_side_type s5_side_in;

   always_comb begin
      num_sum = (asp_pkg::NUM_W'(s4_p1_ff) <<< 5)
              + $signed({8'b0, s4_p2_ff} << 4);
      s5_side_in.num   = num_sum;
      s5_side_in.v2    = s4_v2_ff;
      s5_side_in.yax   = s4_yax_ff;
      s5_side_in.yay   = s4_yay_ff;
      s5_side_in.flags = s4_flags_ff;
      s5_side_in.flags.pit_yneg = num_sum[asp_pkg::NUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v[0] <= 1'b0;
      end else if (adv) begin
         sq_v[0] <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_s[0].n   <= {s4_h2_ff[33:0], 8'b0};
         sq_s[0].res <= '0;
         sq_d[0]     <= s5_side_in;
      end
   end

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      asp_sqrt_cell #(.K(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_v[k]),
         .in_sq     (sq_s[k]),
         .in_side   (sq_d[k]),
         .out_valid (sq_v[k+1]),
         .out_sq    (sq_s[k+1]),
         .out_side  (sq_d[k+1])
      );
   end

   // denominator multiply and magnitudes
   logic                   nm_v [0:NNORM];
   asp_pkg::pair_type      nm_p [0:NNORM];
   asp_pkg::norm_side_type nm_d [0:NNORM];
   logic [53:0]            den;
   logic signed [asp_pkg::NUM_W-1:0] num_l;

   always_comb begin
      num_l = sq_d[NSQ].num;
      den   = {sq_d[NSQ].v2, 1'b0} * sq_s[NSQ].res[asp_pkg::HQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_v[0] <= 1'b0;
      end else if (adv) begin
         nm_v[0] <= sq_v[NSQ];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_p[0].ax    <= {2'b0, den};
         nm_p[0].ay    <= num_l[asp_pkg::NUM_W-1] ? asp_pkg::NUM_W'(-num_l)
                                                  : asp_pkg::NUM_W'(num_l);
         nm_d[0].yax   <= sq_d[NSQ].yax;
         nm_d[0].yay   <= sq_d[NSQ].yay;
         nm_d[0].flags <= sq_d[NSQ].flags;
      end
   end

   for (genvar j = 0; j < NNORM; j++) begin : g_norm
      asp_norm_cell #(.SH(1 << (NNORM - 1 - j))) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (nm_v[j]),
         .in_pair   (nm_p[j]),
         .in_side   (nm_d[j]),
         .out_valid (nm_v[j+1]),
         .out_pair  (nm_p[j+1]),
         .out_side  (nm_d[j+1])
      );
   end

   // CORDIC chain
   logic                cr_v [0:ANGLE_ITER];
   asp_pkg::cordic_type cr_y [0:ANGLE_ITER];
   asp_pkg::cordic_type cr_p [0:ANGLE_ITER];
   asp_pkg::flag_type   cr_f [0:ANGLE_ITER];

   always_comb begin
      cr_v[0]     = nm_v[NNORM];
      cr_f[0]     = nm_d[NNORM].flags;
      cr_y[0].x   = {17'b0, nm_d[NNORM].yax};
      cr_y[0].y   = {17'b0, nm_d[NNORM].yay};
      cr_y[0].ang = '0;
      cr_p[0].x   = {4'b0, nm_p[NNORM].ax[29:0]};
      cr_p[0].y   = {4'b0, nm_p[NNORM].ay[29:0]};
      cr_p[0].ang = '0;
   end

   for (genvar i = 0; i < ANGLE_ITER; i++) begin : g_cordic
      asp_cordic_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (cr_v[i]),
         .in_yaw    (cr_y[i]),
         .in_pit    (cr_p[i]),
         .in_flags  (cr_f[i]),
         .out_valid (cr_v[i+1]),
         .out_yaw   (cr_y[i+1]),
         .out_pit   (cr_p[i+1]),
         .out_flags (cr_f[i+1])
      );
   end

   // output register
   asp_pkg::flag_type  fl;
   logic signed [15:0] yaw_in, pit_in;
   logic signed [15:0] yaw_ff;
   logic signed [14:0] pit_ff;
   logic               close_ff, nos_ff;

   always_comb begin
      fl = cr_f[ANGLE_ITER];
      if (fl.too_close || fl.no_sol) begin
         yaw_in = '0;
         pit_in = '0;
      end else if (fl.h2_zero) begin
         yaw_in = '0;
         pit_in = fl.rz_pos ? 16'(asp_pkg::QUARTER)
                : (fl.rz_neg ? -16'(asp_pkg::QUARTER) : 16'sd0);
      end else begin
         yaw_in = asp_pkg::angle_out(cr_y[ANGLE_ITER].ang, fl.yaw_xneg, fl.yaw_yneg);
         pit_in = asp_pkg::angle_out(cr_p[ANGLE_ITER].ang, 1'b0, fl.pit_yneg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= cr_v[ANGLE_ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_ff   <= yaw_in;
         pit_ff   <= pit_in[14:0];
         close_ff <= fl.too_close;
         nos_ff   <= fl.no_sol && !fl.too_close;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.yaw         = yaw_ff;
   assign rsp_ch.pitch       = pit_ff;
   assign rsp_ch.too_close   = close_ff;
   assign rsp_ch.no_solution = nos_ff;
endmodule
